>>> rtl/zph_pkg.sv
// ----------------------------------------------------------------------------
// zph_pkg
// Shared types, slot layout and opcode codes for the Zobrist hash update core.
// ----------------------------------------------------------------------------
package zph_pkg;

  localparam int Squares    = 64;
  localparam int PieceKinds = 12;
  localparam int EpBase     = PieceKinds * Squares;
  localparam int CastleBase = EpBase + Squares;
  localparam int SideSlot   = CastleBase + 4;
  localparam int KeySlots   = SideSlot + 1;
  localparam int SlotW      = 10;
  localparam int NumReads   = 12;
  localparam int NumPairs   = NumReads / 2;

  // Opcodes of the input word.
  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_SET    = 3'd1;
  localparam logic [2:0] OP_PIECE  = 3'd2;
  localparam logic [2:0] OP_EXTRAS = 3'd3;
  localparam logic [2:0] OP_SIDE   = 3'd4;
  localparam logic [2:0] OP_MOVE   = 3'd5;

  localparam logic [3:0] SPECIAL_CASTLE = 4'd13;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WHITE_ROOK  = 2'd0;
  localparam logic [1:0] CFG_BLACK_ROOK  = 2'd1;
  localparam logic [1:0] CFG_FIRST_BLACK = 2'd2;

  // Read positions; the back end fetches them two at a time, in pairs.
  localparam int RD_SIDE   = 0;
  localparam int RD_FROM   = 1;
  localparam int RD_TO     = 2;
  localparam int RD_EP_B   = 3;
  localparam int RD_EP_A   = 4;
  localparam int RD_CAP    = 5;
  localparam int RD_ROOK_O = 6;
  localparam int RD_ROOK_T = 7;
  localparam int RD_CASTLE = 8;

  typedef logic [SlotW-1:0] slot_t;

  typedef enum logic [1:0] {
    KIND_XOR,
    KIND_SET,
    KIND_LOAD
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      load_en;
    logic [63:0]               value;
    logic [NumReads-1:0]       rd_en;
    slot_t [NumReads-1:0]      addr;
  } entry_t;

  function automatic slot_t piece_slot(input logic [3:0] piece, input logic [5:0] sq);
    piece_slot = {piece, sq};
  endfunction

  function automatic slot_t ep_slot(input logic [5:0] sq);
    ep_slot = SlotW'(EpBase) + {4'b0000, sq};
  endfunction

  function automatic slot_t castle_slot(input logic [1:0] bit_no);
    castle_slot = SlotW'(CastleBase) + {8'b0, bit_no};
  endfunction

endpackage

>>> rtl/zph_front.sv
// ----------------------------------------------------------------------------
// zph_front
// Holds the configuration registers and turns each input word into an entry:
// a key load, a hash set, or a list of key slots to fold into the hash.
// ----------------------------------------------------------------------------
module zph_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data,
  input  logic [2:0]        opcode,
  input  logic [9:0]        word_index,
  input  logic [63:0]       word_value,
  input  logic [3:0]        moved_piece,
  input  logic [5:0]        from_square,
  input  logic [5:0]        to_square,
  input  logic [3:0]        captured_piece,
  input  logic [5:0]        captured_square,
  input  logic [3:0]        special,
  input  logic [6:0]        ep_before,
  input  logic [6:0]        ep_after,
  input  logic [3:0]        castling_change,
  output zph_pkg::entry_t   entry
);

  logic [3:0] white_rook;
  logic [3:0] black_rook;
  logic [3:0] first_black;

  logic       mover_ok;
  logic       qside;
  logic [3:0] rook;
  logic [5:0] rook_origin;
  logic [5:0] rook_target;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_rook  <= 4'd3;
      black_rook  <= 4'd9;
      first_black <= 4'd6;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        zph_pkg::CFG_WHITE_ROOK:  white_rook  <= cfg_data;
        zph_pkg::CFG_BLACK_ROOK:  black_rook  <= cfg_data;
        zph_pkg::CFG_FIRST_BLACK: first_black <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mover_ok    = moved_piece < 4'(zph_pkg::PieceKinds);
  assign rook        = (moved_piece >= first_black) ? black_rook : white_rook;
  assign qside       = to_square[2:0] == 3'd2;
  assign rook_origin = {to_square[5:3], qside ? 3'd0 : 3'd7};
  assign rook_target = {to_square[5:3], qside ? 3'd3 : 3'd5};

  always_comb begin
    entry       = '0;
    entry.kind  = zph_pkg::KIND_XOR;
    entry.value = word_value;
    entry.addr[zph_pkg::RD_SIDE] = zph_pkg::slot_t'(zph_pkg::SideSlot);
    entry.addr[zph_pkg::RD_FROM] = zph_pkg::piece_slot(moved_piece, from_square);
    // On a promotion the promoted piece's key is read at the destination in place
    // of the moved piece's key, so only the promoted piece's key there is folded in.
    entry.addr[zph_pkg::RD_TO]   = zph_pkg::piece_slot(
        (special < 4'(zph_pkg::PieceKinds)) ? special : moved_piece, to_square);
    entry.addr[zph_pkg::RD_EP_B]   = zph_pkg::ep_slot(ep_before[5:0]);
    entry.addr[zph_pkg::RD_EP_A]   = zph_pkg::ep_slot(ep_after[5:0]);
    entry.addr[zph_pkg::RD_CAP]    = zph_pkg::piece_slot(captured_piece, captured_square);
    entry.addr[zph_pkg::RD_ROOK_O] = zph_pkg::piece_slot(rook, rook_origin);
    entry.addr[zph_pkg::RD_ROOK_T] = zph_pkg::piece_slot(rook, rook_target);
    for (int b = 0; b < 4; b++) begin
      entry.addr[zph_pkg::RD_CASTLE + b] = zph_pkg::castle_slot(2'(b));
    end

    unique case (opcode)
      zph_pkg::OP_LOAD: begin
        entry.kind    = zph_pkg::KIND_LOAD;
        entry.load_en = word_index <= 10'(zph_pkg::SideSlot);
        entry.addr[0] = word_index;
      end
      zph_pkg::OP_SET: begin
        entry.kind = zph_pkg::KIND_SET;
      end
      zph_pkg::OP_PIECE: begin
        entry.rd_en[zph_pkg::RD_FROM] = mover_ok;
      end
      zph_pkg::OP_EXTRAS: begin
        entry.rd_en[zph_pkg::RD_EP_A] = ep_after < 7'(zph_pkg::Squares);
        entry.rd_en[zph_pkg::RD_CASTLE +: 4] = castling_change;
      end
      zph_pkg::OP_SIDE: begin
        entry.rd_en[zph_pkg::RD_SIDE] = 1'b1;
      end
      zph_pkg::OP_MOVE: begin
        if (mover_ok) begin
          entry.rd_en[zph_pkg::RD_SIDE] = 1'b1;
          entry.rd_en[zph_pkg::RD_FROM] = 1'b1;
          entry.rd_en[zph_pkg::RD_TO]   = 1'b1;
          entry.rd_en[zph_pkg::RD_CAP]  = captured_piece < 4'(zph_pkg::PieceKinds);
          entry.rd_en[zph_pkg::RD_ROOK_O] = (special == zph_pkg::SPECIAL_CASTLE) &&
                                            (rook < 4'(zph_pkg::PieceKinds));
          entry.rd_en[zph_pkg::RD_ROOK_T] = entry.rd_en[zph_pkg::RD_ROOK_O];
          entry.rd_en[zph_pkg::RD_EP_B] = ep_before < 7'(zph_pkg::Squares);
          entry.rd_en[zph_pkg::RD_EP_A] = ep_after < 7'(zph_pkg::Squares);
          entry.rd_en[zph_pkg::RD_CASTLE +: 4] = castling_change;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/zph_queue.sv
// ----------------------------------------------------------------------------
// zph_queue
// Two-entry queue of decoded words between the front and back ends.
// ----------------------------------------------------------------------------
module zph_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  zph_pkg::entry_t  push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output zph_pkg::entry_t  head
);

  zph_pkg::entry_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/zph_back.sv
// ----------------------------------------------------------------------------
// zph_back
// Key store and hash datapath: fetches two keys a cycle unless the result stalls,
// folds them into the running hash and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module zph_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  zph_pkg::entry_t  head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      hash
);

  logic [63:0] key_mem [zph_pkg::KeySlots];

  logic [zph_pkg::NumPairs-1:0] done;
  logic [zph_pkg::NumPairs-1:0] pair_any;
  logic [zph_pkg::NumPairs-1:0] remaining;
  logic [zph_pkg::NumPairs-1:0] pick;
  logic [1:0]                   a_xor;
  logic                         a_last;
  logic                         a_fire;
  zph_pkg::slot_t               addr0;
  zph_pkg::slot_t               addr1;

  logic        b_valid;
  logic [1:0]  b_xor;
  logic        b_set;
  logic        b_last;
  logic [63:0] b_value;
  logic [63:0] rd0;
  logic [63:0] rd1;
  logic        b_stall;
  logic [63:0] running_hash;
  logic [63:0] hash_next;

  // Issue stage: pick the lowest pair that still has a key to read.
  always_comb begin
    for (int k = 0; k < zph_pkg::NumPairs; k++) begin
      pair_any[k] = head.rd_en[2*k] | head.rd_en[2*k+1];
    end
    remaining = (head.kind == zph_pkg::KIND_XOR) ? (pair_any & ~done) : '0;
    pick      = remaining & (~remaining + zph_pkg::NumPairs'(1));
    a_last    = (remaining & ~pick) == '0;
    a_xor     = 2'b00;
    addr0     = '0;
    addr1     = '0;
    for (int k = 0; k < zph_pkg::NumPairs; k++) begin
      if (pick[k]) begin
        a_xor = a_xor | head.rd_en[2*k +: 2];
        addr0 = addr0 | head.addr[2*k];
        addr1 = addr1 | head.addr[2*k+1];
      end
    end
  end

  assign b_stall = b_valid && b_last && out_valid && !out_ready;
  assign a_fire  = head_valid && !b_stall;
  assign pop     = a_fire && a_last;

  always_ff @(posedge clk) begin
    if (a_fire && head.kind == zph_pkg::KIND_LOAD && head.load_en) begin
      key_mem[head.addr[0]] <= head.value;
    end
  end

  // The read data is only refreshed when the issue stage fires, so it holds
  // through a stall of the result word.
  always_ff @(posedge clk) begin
    if (a_fire) begin
      rd0 <= key_mem[addr0];
      rd1 <= key_mem[addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (!b_stall) begin
      b_xor   <= a_xor;
      b_set   <= head.kind == zph_pkg::KIND_SET;
      b_last  <= a_last;
      b_value <= head.value;
    end
  end

  assign hash_next = b_set ? b_value
                           : running_hash ^ (b_xor[0] ? rd0 : '0) ^ (b_xor[1] ? rd1 : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      done         <= '0;
      b_valid      <= 1'b0;
      running_hash <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (a_fire) begin
        done <= a_last ? '0 : (done | pick);
      end
      if (!b_stall) begin
        b_valid <= a_fire;
      end
      if (b_valid && !b_stall) begin
        running_hash <= hash_next;
      end
      if (b_valid && b_last && !b_stall) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && b_last && !b_stall) begin
      hash <= hash_next;
    end
  end

endmodule

>>> rtl/zobrist_position_hash_update_core.sv
// ----------------------------------------------------------------------------
// zobrist_position_hash_update_core
// Chess position hash unit: a loaded store of 837 random keys and a 64-bit
// running hash, updated one word at a time.
// ----------------------------------------------------------------------------
// Usage: keys are loaded with opcode 0 before use, then a board hash is built
// with opcodes 1 to 4, and each move is applied with opcode 5. Every input
// word returns exactly one result word on the output channel carrying the hash
// after that word, in order. The configuration channel sets the rook piece
// indexes and the first black piece index; it is always ready, and the user
// must write it only while the unit is idle, which the block does not enforce.
// The key store has two read ports and the key reads of a word sit in six
// fixed pairs, so a word issues once for each pair holding a key it needs, or
// once if none does: once for loads, sets, side toggles and piece adds, up to
// three times for extras, two or three times for a typical move and up to six
// times for a castling capture that also changes both en-passant squares and
// all four castling rights. A two-entry queue lets words be accepted while the
// back end is still working or a result waits. Reset clears the hash to zero
// and the configuration to its defaults; the key store keeps whatever it held.
// If the receiver stalls, the result word holds and the back end stops when
// the next result is ready, so the queue fills, after which input ready drops.
// ----------------------------------------------------------------------------
module zobrist_position_hash_update_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [9:0]  word_index,
  input  logic [63:0] word_value,
  input  logic [3:0]  moved_piece,
  input  logic [5:0]  from_square,
  input  logic [5:0]  to_square,
  input  logic [3:0]  captured_piece,
  input  logic [5:0]  captured_square,
  input  logic [3:0]  special,
  input  logic [6:0]  ep_before,
  input  logic [6:0]  ep_after,
  input  logic [3:0]  castling_change,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash
);

  zph_pkg::entry_t entry;
  zph_pkg::entry_t head;
  logic            q_full;
  logic            head_valid;
  logic            pop;

  assign in_ready = !q_full;

  zph_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .opcode          (opcode),
    .word_index      (word_index),
    .word_value      (word_value),
    .moved_piece     (moved_piece),
    .from_square     (from_square),
    .to_square       (to_square),
    .captured_piece  (captured_piece),
    .captured_square (captured_square),
    .special         (special),
    .ep_before       (ep_before),
    .ep_after        (ep_after),
    .castling_change (castling_change),
    .entry           (entry)
  );

  zph_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && in_ready),
    .push_entry (entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  zph_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash       (hash)
  );

endmodule

>>> verif/tb_zobrist_position_hash_update_core.sv
// ----------------------------------------------------------------------------
// tb_zobrist_position_hash_update_core
// Self-checking bench for the Zobrist hash unit. Every key slot is loaded
// first. A short table of directed words then covers the reset state, field
// extremes, every opcode and the no-piece, no-capture, promotion and castling
// cases. Random words follow under several rook and colour settings, with
// random gaps on the input side and random stalls on the result side. Each
// result word is compared with a hash worked out by a predictor in the bench.
// ----------------------------------------------------------------------------
module tb_zobrist_position_hash_update_core;

  localparam logic [2:0] OP_SPARE6      = 3'd6;
  localparam logic [2:0] OP_SPARE7      = 3'd7;
  localparam logic [3:0] NO_PIECE       = 4'd12;
  localparam logic [3:0] NO_PIECE_TOP   = 4'd15;
  localparam logic [3:0] NO_CAPTURE_ALT = 4'd13;
  localparam logic [3:0] SPECIAL_NORMAL = 4'd12;
  localparam logic [3:0] SPECIAL_ALT_LO = 4'd14;
  localparam logic [3:0] SPECIAL_ALT_HI = 4'd15;
  localparam logic [6:0] EP_NONE        = 7'd64;
  localparam logic [6:0] EP_NONE_TOP    = 7'd127;
  localparam int         PLAN_ROWS      = 25;
  localparam int         PHASES         = 6;
  localparam int         RANDOM_WORDS   = 190;

  typedef struct packed {
    logic [2:0]  op;
    logic [9:0]  slot;
    logic [63:0] value;
    logic [3:0]  mover;
    logic [5:0]  from_sq;
    logic [5:0]  to_sq;
    logic [3:0]  cap;
    logic [5:0]  cap_sq;
    logic [3:0]  spec;
    logic [6:0]  ep_b;
    logic [6:0]  ep_a;
    logic [3:0]  rights;
  } hash_word_t;

  typedef struct packed {
    hash_word_t  w;
    logic        typed;
    logic [63:0] want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [3:0]  cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  opcode;
  logic [9:0]  word_index;
  logic [63:0] word_value;
  logic [3:0]  moved_piece;
  logic [5:0]  from_square;
  logic [5:0]  to_square;
  logic [3:0]  captured_piece;
  logic [5:0]  captured_square;
  logic [3:0]  special;
  logic [6:0]  ep_before;
  logic [6:0]  ep_after;
  logic [3:0]  castling_change;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] hash;

  // Bench copies of the block's state and configuration.
  logic [63:0] key_shadow [zph_pkg::KeySlots];
  logic [63:0] hash_shadow = '0;
  logic [3:0]  cfg_white_rook = 4'd3;
  logic [3:0]  cfg_black_rook = 4'd9;
  logic [3:0]  cfg_first_black = 4'd6;

  logic [63:0] hash_due [$];
  plan_row_t   hash_plan [PLAN_ROWS];
  int          mismatches = 0;
  int          results_seen = 0;
  int          words_sent = 0;
  bit          quiet_src = 1'b0;

  zobrist_position_hash_update_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .word_index      (word_index),
    .word_value      (word_value),
    .moved_piece     (moved_piece),
    .from_square     (from_square),
    .to_square       (to_square),
    .captured_piece  (captured_piece),
    .captured_square (captured_square),
    .special         (special),
    .ep_before       (ep_before),
    .ep_after        (ep_after),
    .castling_change (castling_change),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .hash            (hash)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] piece_key(input logic [3:0] piece, input logic [5:0] sq);
    if (piece >= zph_pkg::PieceKinds) return '0;
    return key_shadow[int'(piece) * zph_pkg::Squares + int'(sq)];
  endfunction

  function automatic logic [63:0] ep_key(input logic [6:0] sq);
    if (sq >= zph_pkg::Squares) return '0;
    return key_shadow[zph_pkg::EpBase + int'(sq)];
  endfunction

  function automatic logic [63:0] castle_keys(input logic [3:0] mask);
    logic [63:0] acc;
    acc = '0;
    for (int b = 0; b < 4; b++) begin
      if (mask[b]) acc ^= key_shadow[zph_pkg::CastleBase + b];
    end
    return acc;
  endfunction

  // Advances the bench hash by one accepted word and returns the new value.
  task automatic apply_word_to_hash(input hash_word_t w, output logic [63:0] h);
    logic [3:0] rook;
    logic [5:0] origin;
    logic [5:0] target;
    h = hash_shadow;
    case (w.op)
      zph_pkg::OP_LOAD: begin
        if (w.slot < zph_pkg::KeySlots) key_shadow[w.slot] = w.value;
      end
      zph_pkg::OP_SET: h = w.value;
      zph_pkg::OP_PIECE: h ^= piece_key(w.mover, w.from_sq);
      zph_pkg::OP_EXTRAS: h ^= ep_key(w.ep_a) ^ castle_keys(w.rights);
      zph_pkg::OP_SIDE: h ^= key_shadow[zph_pkg::SideSlot];
      zph_pkg::OP_MOVE: begin
        if (w.mover < zph_pkg::PieceKinds) begin
          h ^= key_shadow[zph_pkg::SideSlot];
          h ^= piece_key(w.mover, w.from_sq) ^ piece_key(w.mover, w.to_sq);
          if (w.cap < zph_pkg::PieceKinds) h ^= piece_key(w.cap, w.cap_sq);
          if (w.spec < zph_pkg::PieceKinds) begin
            h ^= piece_key(w.mover, w.to_sq) ^ piece_key(w.spec, w.to_sq);
          end else if (w.spec == zph_pkg::SPECIAL_CASTLE) begin
            rook = (w.mover >= cfg_first_black) ? cfg_black_rook : cfg_white_rook;
            // A king landing on the c-file castles long; anything else is short.
            origin = {w.to_sq[5:3], (w.to_sq[2:0] == 3'd2) ? 3'd0 : 3'd7};
            target = {w.to_sq[5:3], (w.to_sq[2:0] == 3'd2) ? 3'd3 : 3'd5};
            if (rook < zph_pkg::PieceKinds) begin
              h ^= piece_key(rook, origin) ^ piece_key(rook, target);
            end
          end
          h ^= ep_key(w.ep_b) ^ ep_key(w.ep_a) ^ castle_keys(w.rights);
        end
      end
      default: ;
    endcase
    hash_shadow = h;
  endtask

  function automatic logic [6:0] pick_ep();
    int r;
    r = $urandom_range(19, 0);
    if (r < 12) return EP_NONE;
    else if (r < 19) return 7'($urandom_range(63, 0));
    else return 7'($urandom_range(127, 65));
  endfunction

  // Mostly legal-looking moves with random content; the rest is other opcodes.
  function automatic hash_word_t pick_word();
    hash_word_t w;
    int r;
    w.op      = 3'($urandom_range(7, 0));
    w.slot    = 10'($urandom_range(1023, 0));
    w.value   = {$urandom, $urandom};
    w.mover   = 4'($urandom);
    w.from_sq = 6'($urandom);
    w.to_sq   = 6'($urandom);
    w.cap     = 4'($urandom);
    w.cap_sq  = 6'($urandom);
    w.spec    = 4'($urandom);
    w.ep_b    = 7'($urandom);
    w.ep_a    = 7'($urandom);
    w.rights  = 4'($urandom);
    r = $urandom_range(99, 0);
    if (r < 55) begin
      w.op = zph_pkg::OP_MOVE;
      w.mover = ($urandom_range(9, 0) == 0) ? 4'($urandom_range(15, 12))
                                            : 4'($urandom_range(11, 0));
      r = $urandom_range(9, 0);
      w.cap = (r < 6) ? NO_PIECE : (r < 9) ? 4'($urandom_range(11, 0))
                                           : 4'($urandom_range(15, 13));
      r = $urandom_range(19, 0);
      if (r < 12) begin
        w.spec = SPECIAL_NORMAL;
      end else if (r < 14) begin
        w.spec = 4'($urandom_range(11, 0));
      end else if (r < 19) begin
        w.spec = zph_pkg::SPECIAL_CASTLE;
        if ($urandom_range(4, 0) != 0) begin
          w.to_sq = {($urandom_range(1, 0) != 0) ? 3'd7 : 3'd0,
                     ($urandom_range(1, 0) != 0) ? 3'd2 : 3'd6};
        end
      end else begin
        w.spec = 4'($urandom_range(15, 14));
      end
      w.ep_b = pick_ep();
      w.ep_a = pick_ep();
      if ($urandom_range(1, 0) != 0) w.rights = '0;
    end else if (r < 70) begin
      w.op = zph_pkg::OP_PIECE;
      if ($urandom_range(9, 0) != 0) w.mover = 4'($urandom_range(11, 0));
    end else if (r < 78) begin
      w.op = zph_pkg::OP_EXTRAS;
      w.ep_a = pick_ep();
    end else if (r < 85) begin
      w.op = zph_pkg::OP_SIDE;
    end else if (r < 89) begin
      w.op = zph_pkg::OP_SET;
    end else if (r < 97) begin
      w.op = zph_pkg::OP_LOAD;
    end else begin
      w.op = ($urandom_range(1, 0) != 0) ? OP_SPARE6 : OP_SPARE7;
    end
    return w;
  endfunction

  task automatic note_hash_mismatch(input string what, input logic [63:0] got,
                                    input logic [63:0] want);
    mismatches++;
    $display("hash mismatch at result %0d: %s, got %h, expected %h",
             results_seen, what, got, want);
  endtask

  // Presents one word after a random gap and holds it until it is taken.
  task automatic send_word(input hash_word_t w, input logic typed, input logic [63:0] want);
    int gap;
    logic [63:0] h;
    words_sent++;
    if (words_sent % 50 == 0) quiet_src = ($urandom_range(2, 0) == 0);
    gap = quiet_src ? 0 : $urandom_range(4, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    opcode          <= w.op;
    word_index      <= w.slot;
    word_value      <= w.value;
    moved_piece     <= w.mover;
    from_square     <= w.from_sq;
    to_square       <= w.to_sq;
    captured_piece  <= w.cap;
    captured_square <= w.cap_sq;
    special         <= w.spec;
    ep_before       <= w.ep_b;
    ep_after        <= w.ep_a;
    castling_change <= w.rights;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_word_to_hash(w, h);
    hash_due.push_back(typed ? want : h);
  endtask

  task automatic wait_drained();
    while (hash_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_config(input logic [3:0] white, input logic [3:0] black,
                              input logic [3:0] first);
    logic [3:0] vals [3];
    logic [1:0] idxs [3];
    vals = '{white, black, first};
    idxs = '{zph_pkg::CFG_WHITE_ROOK, zph_pkg::CFG_BLACK_ROOK, zph_pkg::CFG_FIRST_BLACK};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cfg_white_rook  = white;
    cfg_black_rook  = black;
    cfg_first_black = first;
  endtask

  // Result side: ready may drop for a random hold after a word, and now and then
  // while nothing is waiting, except in quiet stretches.
  always @(posedge clk) begin : result_sink
    int hold;
    int taken;
    bit quiet_sink;
    if (rst) begin
      out_ready <= 1'b0;
      hold = 0;
      taken = 0;
      quiet_sink = 1'b0;
    end else if (!out_ready) begin
      if (hold == 0) out_ready <= 1'b1;
      else hold--;
    end else if (out_valid) begin
      taken++;
      if (taken % 40 == 0) quiet_sink = ($urandom_range(2, 0) == 0);
      hold = quiet_sink ? 0 : $urandom_range(4, 0);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end
    end else if (!quiet_sink && $urandom_range(7, 0) == 0) begin
      out_ready <= 1'b0;
      hold = $urandom_range(3, 0);
    end
  end

  always @(posedge clk) begin : hash_checker
    logic [63:0] want;
    if (!rst && out_valid && out_ready) begin
      if (hash_due.size() == 0) begin
        note_hash_mismatch("result word with nothing outstanding", hash, '0);
      end else begin
        want = hash_due.pop_front();
        if (hash !== want) note_hash_mismatch("hash field", hash, want);
      end
      results_seen++;
    end
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    hash_word_t w;
    logic [3:0] phase_white [PHASES];
    logic [3:0] phase_black [PHASES];
    logic [3:0] phase_first [PHASES];
    phase_white = '{4'd3, 4'd0,  4'd11, 4'd15, 4'd7,  4'd3};
    phase_black = '{4'd9, 4'd11, 4'd0,  4'd12, 4'd13, 4'd9};
    phase_first = '{4'd6, 4'd1,  4'd11, 4'd0,  4'd15, 4'd6};
    // Directed words. The typed hashes follow from the keys loaded in the rows
    // above them; the rest are left to the predictor.
    hash_plan = '{
      '{'{OP_SPARE6, 0, 0, NO_PIECE, 0, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE, EP_NONE, 0},
        1'b1, 64'h0},
      '{'{zph_pkg::OP_LOAD, 10'(zph_pkg::SideSlot), 64'h8000_0000_0000_0001, NO_PIECE,
          0, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE, EP_NONE, 0}, 1'b1, 64'h0},
      '{'{zph_pkg::OP_LOAD, 10'd1023, 64'hFFFF_FFFF_FFFF_FFFF, NO_PIECE, 0, 0, NO_PIECE,
          0, SPECIAL_NORMAL, EP_NONE, EP_NONE, 0}, 1'b1, 64'h0},
      '{'{zph_pkg::OP_SIDE, 0, 0, NO_PIECE, 0, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE,
          EP_NONE, 0}, 1'b1, 64'h8000_0000_0000_0001},
      '{'{zph_pkg::OP_SET, 0, 64'hFFFF_FFFF_FFFF_FFFF, NO_PIECE, 0, 0, NO_PIECE, 0,
          SPECIAL_NORMAL, EP_NONE, EP_NONE, 0}, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{'{zph_pkg::OP_SET, 0, 0, NO_PIECE, 0, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE,
          EP_NONE, 0}, 1'b1, 64'h0},
      '{'{zph_pkg::OP_LOAD, 0, 64'hFFFF_FFFF_FFFF_FFFF, NO_PIECE, 0, 0, NO_PIECE, 0,
          SPECIAL_NORMAL, EP_NONE, EP_NONE, 0}, 1'b1, 64'h0},
      '{'{zph_pkg::OP_PIECE, 0, 0, 0, 0, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE, EP_NONE,
          0}, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{'{zph_pkg::OP_PIECE, 0, 0, NO_PIECE, 0, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE,
          EP_NONE, 0}, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{'{zph_pkg::OP_PIECE, 0, 0, NO_PIECE_TOP, 63, 63, NO_PIECE, 0, SPECIAL_NORMAL,
          EP_NONE, EP_NONE, 0}, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{'{zph_pkg::OP_LOAD, 10'd767, 64'h0123_4567_89AB_CDEF, NO_PIECE, 0, 0, NO_PIECE, 0,
          SPECIAL_NORMAL, EP_NONE, EP_NONE, 0}, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
      '{'{zph_pkg::OP_PIECE, 0, 0, 11, 63, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE,
          EP_NONE, 0}, 1'b1, 64'hFEDC_BA98_7654_3210},
      '{'{zph_pkg::OP_EXTRAS, 0, 0, NO_PIECE, 0, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE,
          EP_NONE, 0}, 1'b1, 64'hFEDC_BA98_7654_3210},
      '{'{zph_pkg::OP_EXTRAS, 0, 0, NO_PIECE, 0, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE,
          EP_NONE_TOP, 0}, 1'b1, 64'hFEDC_BA98_7654_3210},
      '{'{zph_pkg::OP_EXTRAS, 0, 0, NO_PIECE, 0, 0, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE,
          0, 15}, 1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, NO_PIECE, 12, 28, 3, 28, SPECIAL_NORMAL, 20, 20, 15},
        1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, NO_PIECE_TOP, 1, 18, 0, 18, zph_pkg::SPECIAL_CASTLE, 0,
          63, 5}, 1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, 0, 12, 28, NO_PIECE, 0, SPECIAL_NORMAL, EP_NONE, 20, 0},
        1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, 6, 51, 35, NO_CAPTURE_ALT, 0, SPECIAL_ALT_LO, 20, 43, 0},
        1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, 0, 36, 43, 6, 35, SPECIAL_ALT_HI, 43, EP_NONE, 0},
        1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, 0, 52, 61, 9, 61, 4, EP_NONE, EP_NONE, 4'b0100},
        1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, 5, 4, 6, NO_PIECE, 0, zph_pkg::SPECIAL_CASTLE, EP_NONE,
          EP_NONE, 4'b0011}, 1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, 11, 60, 58, NO_PIECE, 0, zph_pkg::SPECIAL_CASTLE, 63, 0,
          4'b1100}, 1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, 11, 63, 0, 11, 63, zph_pkg::SPECIAL_CASTLE, 0, 63,
          4'b1111}, 1'b0, 64'h0},
      '{'{zph_pkg::OP_MOVE, 0, 0, 6, 12, 4, 0, 4, 11, EP_NONE, EP_NONE, 0}, 1'b0, 64'h0}
    };

    in_valid        <= 1'b0;
    opcode          <= '0;
    word_index      <= '0;
    word_value      <= '0;
    moved_piece     <= '0;
    from_square     <= '0;
    to_square       <= '0;
    captured_piece  <= '0;
    captured_square <= '0;
    special         <= '0;
    ep_before       <= '0;
    ep_after        <= '0;
    castling_change <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every key slot is loaded before any word can read one.
    for (int s = 0; s < zph_pkg::KeySlots; s++) begin
      w = pick_word();
      w.op = zph_pkg::OP_LOAD;
      w.slot = 10'(s);
      send_word(w, 1'b0, '0);
    end

    for (int i = 0; i < PLAN_ROWS; i++)
      send_word(hash_plan[i].w, hash_plan[i].typed, hash_plan[i].want);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        in_valid <= 1'b0;
        wait_drained();
        write_config(phase_white[p], phase_black[p], phase_first[p]);
      end
      repeat (RANDOM_WORDS) send_word(pick_word(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    wait_drained();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
